>>> rtl/asbs_pkg.sv
// Package for the acked serial bit sender: codes, widths, queue entry types.
// Used by every module of the block; depends on nothing.
package asbs_pkg;

    // Character and field widths
    localparam int BITS_PER_CHAR = 8;
    localparam int DATA_W        = 8;
    localparam int BIT_CNT_W     = (BITS_PER_CHAR > 1) ? $clog2(BITS_PER_CHAR) : 1;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BITS_PER_CHAR - 1);
    localparam int TICK_W        = 16;
    localparam int RETRY_W       = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;

    // Register reset values
    localparam logic [TICK_W-1:0]  TIMEOUT_RST = TICK_W'(200);
    localparam logic [RETRY_W-1:0] RETRY_RST   = RETRY_W'(5);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY   = 1'b1;

    // Input op and acknowledge codes
    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_ACK  = 2'd2;
    localparam logic [1:0] ACK_BIT = 2'd1;
    localparam logic [1:0] ACK_END = 2'd2;

    // Queue depth between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified command
    typedef enum logic [1:0] {
        CMD_SEND    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_ACK_BIT = 2'd2,
        CMD_ACK_END = 2'd3
    } t_cmd;

    // Result kinds
    typedef enum logic [2:0] {
        K_PULSE  = 3'd0,
        K_BYTE   = 3'd1,
        K_MSG    = 3'd2,
        K_BITERR = 3'd3,
        K_FINERR = 3'd4
    } t_kind;

    // Back-end sender state
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BUSY  = 2'd1,
        ST_FINAL = 2'd2
    } t_state;

    typedef struct packed {
        t_cmd              cmd;
        logic [DATA_W-1:0] data;
    } t_qentry;

    // Write and read sides of the command queue
    typedef struct packed {
        logic    valid;
        t_qentry entry;
    } t_qport;

endpackage

>>> rtl/asbs_front.sv
// Front end: accepts stream transactions and classifies them into commands.
// Ops and acknowledge kinds that mean nothing are dropped here. Uses asbs_pkg.
module asbs_front
    import asbs_pkg::*;
(
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic [3:0]  i_s_axis_tuser,   // [1:0] op, [3:2] ack_kind
    input  logic        i_q_full,
    output t_qport      o_q_wr
);

    logic [1:0] op;
    logic [1:0] ack_kind;
    logic       accept;

    assign op       = i_s_axis_tuser[1:0];
    assign ack_kind = i_s_axis_tuser[3:2];

    assign o_s_axis_tready = !i_q_full;
    assign accept          = i_s_axis_tvalid && !i_q_full;

    // Decode op into a command; unknown codes push nothing
    always_comb begin
        o_q_wr.valid      = 1'b0;
        o_q_wr.entry.cmd  = CMD_SEND;
        o_q_wr.entry.data = i_s_axis_tdata;
        case (op)
            OP_SEND: begin
                o_q_wr.valid     = accept;
                o_q_wr.entry.cmd = CMD_SEND;
            end
            OP_TICK: begin
                o_q_wr.valid     = accept;
                o_q_wr.entry.cmd = CMD_TICK;
            end
            OP_ACK: begin
                case (ack_kind)
                    ACK_BIT: begin
                        o_q_wr.valid     = accept;
                        o_q_wr.entry.cmd = CMD_ACK_BIT;
                    end
                    ACK_END: begin
                        o_q_wr.valid     = accept;
                        o_q_wr.entry.cmd = CMD_ACK_END;
                    end
                    default: o_q_wr.valid = 1'b0;
                endcase
            end
            default: o_q_wr.valid = 1'b0;
        endcase
    end

endmodule

>>> rtl/asbs_queue.sv
// Small command queue between front and back ends.
// Register-based circular buffer; uses asbs_pkg for entry type and depth.
module asbs_queue
    import asbs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qport i_wr,
    output logic   o_full,
    output t_qport o_rd,
    input  logic   i_pop
);

    t_qentry             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count,  n_count;
    logic                push, pop;

    assign o_full   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push     = i_wr.valid && !o_full;
    assign pop      = i_pop && (r_count != '0);
    assign o_rd.valid = (r_count != '0);
    assign o_rd.entry = r_mem[r_rd_ptr];

    // Pointer and count update with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr.entry;
        end
    end

endmodule

>>> rtl/asbs_back.sv
// Back end: stop-and-wait bit sender state machine, config registers and
// the registered result stage. Uses asbs_pkg.
module asbs_back
    import asbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_qport                i_q_rd,
    output logic                  o_q_pop,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [7:0]            o_m_axis_tdata,   // [0] line_value, [7:1] zero
    output logic [2:0]            o_m_axis_tuser    // [2:0] kind
);

    t_state                r_state, n_state;
    logic [DATA_W-1:0]     r_shift, n_shift;
    logic [BIT_CNT_W-1:0]  r_bit_count, n_bit_count;
    logic [TICK_W-1:0]     r_tick_count, n_tick_count;
    logic [RETRY_W-1:0]    r_retry_count, n_retry_count;
    logic                  r_null_byte, n_null_byte;
    logic [TICK_W-1:0]     r_timeout_ticks;
    logic [RETRY_W-1:0]    r_retry_limit;
    logic                  r_out_valid;
    t_kind                 r_out_kind;
    logic                  r_out_line;

    logic                  out_free;
    logic                  fire;
    t_cmd                  cmd;
    logic [DATA_W-1:0]     shifted;
    logic                  tick_expired;
    logic                  retry_exhausted;
    logic                  res_valid;
    t_kind                 res_kind;
    logic                  res_line;

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign fire     = i_q_rd.valid && out_free;
    assign o_q_pop  = fire;
    assign cmd      = i_q_rd.entry.cmd;
    assign shifted  = r_shift >> 1;

    assign tick_expired    = ({1'b0, r_tick_count} + 17'd1) > {1'b0, r_timeout_ticks};
    assign retry_exhausted = ({1'b0, r_retry_count} + 9'd1) >= {1'b0, r_retry_limit};

    // Next state
    always_comb begin
        n_state = r_state;
        if (fire) begin
            case (r_state)
                ST_IDLE: begin
                    if (cmd == CMD_SEND) n_state = ST_BUSY;
                end
                ST_BUSY: begin
                    if (cmd == CMD_TICK) begin
                        if (tick_expired && retry_exhausted) n_state = ST_IDLE;
                    end else if (cmd == CMD_ACK_BIT || cmd == CMD_ACK_END) begin
                        if (r_bit_count == LAST_BIT) begin
                            n_state = (r_null_byte && cmd == CMD_ACK_BIT) ? ST_FINAL
                                                                          : ST_IDLE;
                        end
                    end
                end
                ST_FINAL: begin
                    if ((cmd == CMD_TICK && tick_expired) || cmd == CMD_ACK_END) begin
                        n_state = ST_IDLE;
                    end
                end
                default: n_state = ST_IDLE;
            endcase
        end
    end

    // Datapath updates and result
    always_comb begin
        n_shift       = r_shift;
        n_bit_count   = r_bit_count;
        n_tick_count  = r_tick_count;
        n_retry_count = r_retry_count;
        n_null_byte   = r_null_byte;
        res_valid     = 1'b0;
        res_kind      = K_PULSE;
        res_line      = 1'b0;
        if (fire) begin
            case (r_state)
                ST_IDLE: begin
                    if (cmd == CMD_SEND) begin
                        n_shift       = i_q_rd.entry.data;
                        n_bit_count   = '0;
                        n_tick_count  = '0;
                        n_retry_count = '0;
                        n_null_byte   = (i_q_rd.entry.data == '0);
                        res_valid     = 1'b1;
                        res_line      = i_q_rd.entry.data[0];
                    end
                end
                ST_BUSY: begin
                    if (cmd == CMD_TICK) begin
                        if (!tick_expired) begin
                            n_tick_count = r_tick_count + 1'b1;
                        end else begin
                            n_tick_count = '0;
                            res_valid    = 1'b1;
                            if (retry_exhausted) begin
                                n_retry_count = '0;
                                res_kind      = K_BITERR;
                            end else begin
                                n_retry_count = r_retry_count + 1'b1;
                                res_line      = r_shift[0];
                            end
                        end
                    end else if (cmd == CMD_ACK_BIT || cmd == CMD_ACK_END) begin
                        n_tick_count  = '0;
                        n_retry_count = '0;
                        n_shift       = shifted;
                        res_valid     = 1'b1;
                        if (r_bit_count != LAST_BIT) begin
                            n_bit_count = r_bit_count + 1'b1;
                            res_line    = shifted[0];
                        end else begin
                            n_bit_count = '0;
                            res_kind    = (r_null_byte && cmd == CMD_ACK_END) ? K_MSG
                                                                               : K_BYTE;
                        end
                    end
                end
                ST_FINAL: begin
                    if (cmd == CMD_TICK) begin
                        if (!tick_expired) begin
                            n_tick_count = r_tick_count + 1'b1;
                        end else begin
                            n_tick_count = '0;
                            res_valid    = 1'b1;
                            res_kind     = K_FINERR;
                        end
                    end else if (cmd == CMD_ACK_END) begin
                        n_tick_count = '0;
                        res_valid    = 1'b1;
                        res_kind     = K_MSG;
                    end
                end
                default: res_valid = 1'b0;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_shift       <= '0;
            r_bit_count   <= '0;
            r_tick_count  <= '0;
            r_retry_count <= '0;
            r_null_byte   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_shift       <= n_shift;
            r_bit_count   <= n_bit_count;
            r_tick_count  <= n_tick_count;
            r_retry_count <= n_retry_count;
            r_null_byte   <= n_null_byte;
            if (out_free) begin
                r_out_valid <= fire && res_valid;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_kind <= res_kind;
            r_out_line <= res_line;
        end
    end

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TIMEOUT_RST;
            r_retry_limit   <= RETRY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIMEOUT: r_timeout_ticks <= i_cfg_data;
                CFG_RETRY:   r_retry_limit   <= i_cfg_data[RETRY_W-1:0];
                default:     r_retry_limit   <= r_retry_limit;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_line};
    assign o_m_axis_tuser  = r_out_kind;

    // Only a bit pulse drives the line high
    a_line_only_on_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_line) |-> (r_out_kind == K_PULSE))
        else $error("line_value set on a non-pulse result");

    // The end wait is entered only for the terminating byte
    a_final_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINAL) |-> r_null_byte)
        else $error("final wait without a zero byte");

    // Within a byte the bit counter holds or steps by one
    a_bit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BUSY && $past(r_state) == ST_BUSY) |->
        (r_bit_count == $past(r_bit_count) ||
         r_bit_count == $past(r_bit_count) + 1'b1))
        else $error("bit counter skipped");

endmodule

>>> rtl/acked_serial_bit_sender_unit.sv
// Acked serial bit sender: an accepted transaction waits in the queue, then any result
// it gives is registered. Throughput one transaction per cycle unless the output stalls,
// set by the back-end state machine that retires one queued command per cycle;
// a 2-entry queue decouples the front end.
// Synchronous active-low reset clears state to idle, timeout to 200, retries to 5.
// Depends on asbs_pkg, asbs_front, asbs_queue, asbs_back.
module acked_serial_bit_sender_unit
    import asbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] data_byte
    input  logic [3:0]            i_s_axis_tuser,   // [1:0] op, [3:2] ack_kind
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [7:0]            o_m_axis_tdata,   // [0] line_value, [7:1] zero
    output logic [2:0]            o_m_axis_tuser,   // [2:0] kind
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_qport q_wr;
    t_qport q_rd;
    logic   q_full;
    logic   q_pop;

    asbs_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_full        (q_full),
        .o_q_wr          (q_wr)
    );

    asbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .o_rd    (q_rd),
        .i_pop   (q_pop)
    );

    asbs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_q_rd          (q_rd),
        .o_q_pop         (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
